// File: hdl/tcf_pkg.sv
// Package with the shared types, codes and sequence helpers of the TCP control engine.
package tcf_pkg;

  // Input action codes.
  localparam logic [2:0] ACT_SEGMENT     = 3'd0;
  localparam logic [2:0] ACT_PASSIVE     = 3'd1;
  localparam logic [2:0] ACT_ACTIVE      = 3'd2;
  localparam logic [2:0] ACT_CLOSE       = 3'd3;
  localparam logic [2:0] ACT_TICK        = 3'd4;
  localparam logic [2:0] ACT_COMMIT_SENT = 3'd5;
  localparam logic [2:0] ACT_COMMIT_RCVD = 3'd6;
  localparam logic [2:0] ACT_SET_WINDOW  = 3'd7;

  // Event codes of a result.
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_ESTABLISHED = 3'd1;
  localparam logic [2:0] EV_PEER_CLOSED = 3'd2;
  localparam logic [2:0] EV_RESET       = 3'd3;
  localparam logic [2:0] EV_CLOSED      = 3'd4;
  localparam logic [2:0] EV_DATA        = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LOCAL_PORT   = 3'd0;
  localparam logic [2:0] CFG_REMOTE_PORT  = 3'd1;
  localparam logic [2:0] CFG_RCV_WINDOW   = 3'd2;
  localparam logic [2:0] CFG_RETX_TICKS   = 3'd3;
  localparam logic [2:0] CFG_TWAIT_TICKS  = 3'd4;

  // Flag byte bits.
  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_ACK = 4;
  localparam logic [7:0] FL_SYN     = 8'h02;
  localparam logic [7:0] FL_RST     = 8'h04;
  localparam logic [7:0] FL_ACK     = 8'h10;
  localparam logic [7:0] FL_SYN_ACK = 8'h12;
  localparam logic [7:0] FL_FIN_ACK = 8'h11;
  localparam logic [7:0] FL_RST_ACK = 8'h14;

  localparam logic [30:0] MAX_SEND_COMMIT = 31'h4000_0000;
  localparam logic [29:0] WIRE_WIN_MAX    = 30'd65535;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_LOCAL_PORT  = 16'd1;
  localparam logic [15:0] RST_REMOTE_PORT = 16'd0;
  localparam logic [29:0] RST_RCV_WINDOW  = 30'd65535;
  localparam logic [15:0] RST_RETX_TICKS  = 16'd1000;
  localparam logic [23:0] RST_TWAIT_TICKS = 24'd120000;

  typedef enum logic [3:0] {
    ST_CLOSED     = 4'd0,
    ST_LISTEN     = 4'd1,
    ST_SYN_SENT   = 4'd2,
    ST_SYN_RCVD   = 4'd3,
    ST_ESTAB      = 4'd4,
    ST_FIN_WAIT_1 = 4'd5,
    ST_FIN_WAIT_2 = 4'd6,
    ST_CLOSE_WAIT = 4'd7,
    ST_CLOSING    = 4'd8,
    ST_LAST_ACK   = 4'd9,
    ST_TIME_WAIT  = 4'd10
  } conn_state_t;

  // Kind of reply segment that one request produces.
  typedef enum logic [2:0] {
    RK_NONE,
    RK_ACK,
    RK_RST,
    RK_SYN,
    RK_SYN_ACK,
    RK_FIN_ACK,
    RK_RETX
  } reply_kind_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] seg_src_port;
    logic [15:0] seg_dst_port;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [7:0]  seg_flags;
    logic [30:0] data_len;
    logic [29:0] peer_window;
    logic [31:0] init_seq;
    logic        fin_present;
    logic [31:0] fin_seq;
  } item_t;

  typedef struct packed {
    logic        emit;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [7:0]  out_flags;
    logic [15:0] out_window;
    logic [2:0]  event_res;
    logic        accepted;
  } reply_t;

  typedef struct packed {
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [29:0] rcv_window;
    logic [15:0] retx_ticks;
    logic [23:0] twait_ticks;
  } cfg_t;

  typedef struct packed {
    logic        wr;
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_wr_t;

  // Serial (modulo 2^32) comparisons.
  function automatic logic sq_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic sq_le(input logic [31:0] a, input logic [31:0] b);
    return !sq_before(b, a);
  endfunction

endpackage

// File: hdl/tcf_ifs.sv
// Handshake interfaces for the request, result and configuration channels.
interface tcf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] seg_src_port;
  logic [15:0] seg_dst_port;
  logic [31:0] seg_seq;
  logic [31:0] seg_ack;
  logic [7:0]  seg_flags;
  logic [30:0] data_len;
  logic [29:0] peer_window;
  logic [31:0] init_seq;
  logic        fin_present;
  logic [31:0] fin_seq;
  modport source (output valid, action, seg_src_port, seg_dst_port, seg_seq, seg_ack,
                  seg_flags, data_len, peer_window, init_seq, fin_present, fin_seq,
                  input ready);
  modport sink (input valid, action, seg_src_port, seg_dst_port, seg_seq, seg_ack,
                seg_flags, data_len, peer_window, init_seq, fin_present, fin_seq,
                output ready);
endinterface

interface tcf_out_if;
  logic        valid;
  logic        ready;
  logic        emit;
  logic [15:0] out_src_port;
  logic [15:0] out_dst_port;
  logic [31:0] out_seq;
  logic [31:0] out_ack;
  logic [7:0]  out_flags;
  logic [15:0] out_window;
  logic [2:0]  event_res;
  logic        accepted;
  modport source (output valid, emit, out_src_port, out_dst_port, out_seq, out_ack,
                  out_flags, out_window, event_res, accepted, input ready);
  modport sink (input valid, emit, out_src_port, out_dst_port, out_seq, out_ack,
                out_flags, out_window, event_res, accepted, output ready);
endinterface

interface tcf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/tcf_cfg_regs.sv
// Configuration register file of the TCP control engine.
module tcf_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  input  tcf_pkg::cfg_wr_t wr,
  output tcf_pkg::cfg_t   cfg
);

  tcf_pkg::cfg_t cfg_r;

  // Register writes by index; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_port  <= tcf_pkg::RST_LOCAL_PORT;
      cfg_r.remote_port <= tcf_pkg::RST_REMOTE_PORT;
      cfg_r.rcv_window  <= tcf_pkg::RST_RCV_WINDOW;
      cfg_r.retx_ticks  <= tcf_pkg::RST_RETX_TICKS;
      cfg_r.twait_ticks <= tcf_pkg::RST_TWAIT_TICKS;
    end else if (wr.wr) begin
      case (wr.index)
        tcf_pkg::CFG_LOCAL_PORT:  cfg_r.local_port  <= wr.data[15:0];
        tcf_pkg::CFG_REMOTE_PORT: cfg_r.remote_port <= wr.data[15:0];
        tcf_pkg::CFG_RCV_WINDOW:  cfg_r.rcv_window  <= wr.data[29:0];
        tcf_pkg::CFG_RETX_TICKS:  cfg_r.retx_ticks  <= wr.data[15:0];
        tcf_pkg::CFG_TWAIT_TICKS: cfg_r.twait_ticks <= wr.data[23:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/tcf_engine.sv
// Connection state, sequence variables and per-request decision logic.
module tcf_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  tcf_pkg::item_t   item,
  input  tcf_pkg::cfg_t    cfg,
  input  tcf_pkg::cfg_wr_t wr,
  output tcf_pkg::reply_t  reply
);

  tcf_pkg::conn_state_t st_r, st_nxt;
  logic [31:0] suna_r, suna_nxt, snxt_r, snxt_nxt;
  logic [29:0] swnd_r, swnd_nxt;
  logic [31:0] wus_r, wus_nxt, wua_r, wua_nxt;
  logic [31:0] rnxt_r, rnxt_nxt;
  logic [29:0] rwnd_r, rwnd_nxt;
  logic [31:0] iss_r, iss_nxt, irs_r, irs_nxt;
  logic [15:0] pport_r, pport_nxt;
  logic        passive_r, passive_nxt, finsent_r, finsent_nxt;
  logic        pend_r, pend_nxt;
  logic [15:0] rtoc_r, rtoc_nxt;
  logic [23:0] twc_r, twc_nxt;
  logic [31:0] sv_seq_r, sv_ack_r;
  logic [15:0] sv_sp_r, sv_dp_r, sv_win_r;
  logic [7:0]  sv_flags_r;

  tcf_pkg::reply_kind_t rk;
  logic [2:0]  ev;
  logic        acc;
  logic        rst_f, ack_f, syn_f, fin_f;
  logic [31:0] seg_len;
  logic [15:0] wire_win;

  assign rst_f   = item.seg_flags[tcf_pkg::FLAG_RST];
  assign ack_f   = item.seg_flags[tcf_pkg::FLAG_ACK];
  assign syn_f   = item.seg_flags[tcf_pkg::FLAG_SYN];
  assign fin_f   = item.seg_flags[tcf_pkg::FLAG_FIN];
  assign seg_len = {1'b0, item.data_len} + {31'd0, syn_f} + {31'd0, fin_f};
  assign wire_win = (rwnd_nxt > tcf_pkg::WIRE_WIN_MAX) ? 16'hFFFF : rwnd_nxt[15:0];

  // Next state of the connection and the kind of reply.
  always_comb begin
    logic synch, ok, rep_syn, acceptable, cont, became, fin_acked, pfin, len0;
    logic [31:0] w0, w1;
    st_nxt = st_r; suna_nxt = suna_r; snxt_nxt = snxt_r; swnd_nxt = swnd_r;
    wus_nxt = wus_r; wua_nxt = wua_r; rnxt_nxt = rnxt_r; rwnd_nxt = rwnd_r;
    iss_nxt = iss_r; irs_nxt = irs_r; pport_nxt = pport_r;
    passive_nxt = passive_r; finsent_nxt = finsent_r; pend_nxt = pend_r;
    rtoc_nxt = rtoc_r; twc_nxt = twc_r;
    rk = tcf_pkg::RK_NONE; ev = tcf_pkg::EV_NONE; acc = 1'b0;
    pfin = 1'b0; cont = 1'b0; became = 1'b0; fin_acked = 1'b0;
    synch = (st_r >= tcf_pkg::ST_SYN_RCVD) && (st_r <= tcf_pkg::ST_TIME_WAIT);
    ok = ack_f && tcf_pkg::sq_before(iss_r, item.seg_ack) &&
         tcf_pkg::sq_le(item.seg_ack, snxt_r);
    rep_syn = (st_r == tcf_pkg::ST_SYN_RCVD) && !passive_r && syn_f && ack_f &&
              (item.data_len == 31'd0) && (item.seg_seq + 32'd1 == rnxt_r);
    // Receive window acceptability of the segment.
    w0 = item.seg_seq - rnxt_r;
    w1 = item.seg_seq + seg_len - 32'd1 - rnxt_r;
    len0 = (seg_len == 32'd0);
    if (len0) begin
      acceptable = (rwnd_r == 30'd0) ? (item.seg_seq == rnxt_r) : (w0 < {2'b00, rwnd_r});
    end else begin
      acceptable = (rwnd_r != 30'd0) &&
                   ((w0 < {2'b00, rwnd_r}) || (w1 < {2'b00, rwnd_r}));
    end

    if (go) begin
      case (item.action)
        tcf_pkg::ACT_SEGMENT: begin
          if (item.seg_dst_port == cfg.local_port) begin
            if (st_r == tcf_pkg::ST_CLOSED) begin
              if (!rst_f) rk = tcf_pkg::RK_RST;
            end else if (st_r == tcf_pkg::ST_LISTEN) begin
              if (rst_f) begin
                rk = tcf_pkg::RK_NONE;
              end else if (ack_f) begin
                rk = tcf_pkg::RK_RST;
              end else if (syn_f) begin
                pport_nxt = item.seg_src_port;
                irs_nxt = item.seg_seq;
                rnxt_nxt = item.seg_seq + 32'd1;
                iss_nxt = item.init_seq; suna_nxt = item.init_seq;
                snxt_nxt = item.init_seq + 32'd1;
                swnd_nxt = item.peer_window; wus_nxt = item.seg_seq;
                wua_nxt = item.seg_ack;
                st_nxt = tcf_pkg::ST_SYN_RCVD;
                rk = tcf_pkg::RK_SYN_ACK;
              end
            end else if (st_r == tcf_pkg::ST_SYN_SENT) begin
              if (ack_f && !ok) begin
                if (!rst_f) rk = tcf_pkg::RK_RST;
              end else if (rst_f) begin
                if (ok) begin
                  st_nxt = tcf_pkg::ST_CLOSED; pend_nxt = 1'b0; ev = tcf_pkg::EV_RESET;
                end
              end else if (syn_f) begin
                irs_nxt = item.seg_seq;
                rnxt_nxt = item.seg_seq + 32'd1;
                swnd_nxt = item.peer_window; wus_nxt = item.seg_seq;
                wua_nxt = item.seg_ack;
                if (ok) begin
                  suna_nxt = item.seg_ack; pend_nxt = 1'b0;
                  st_nxt = tcf_pkg::ST_ESTAB; rk = tcf_pkg::RK_ACK;
                  ev = tcf_pkg::EV_ESTABLISHED;
                end else begin
                  st_nxt = tcf_pkg::ST_SYN_RCVD; rk = tcf_pkg::RK_SYN_ACK;
                end
              end
            end else if (synch) begin
              if ((st_r == tcf_pkg::ST_TIME_WAIT) && fin_f && (item.data_len == 31'd0) &&
                  (item.seg_seq + 32'd1 == rnxt_r)) begin
                st_nxt = tcf_pkg::ST_TIME_WAIT; pend_nxt = 1'b0;
                twc_nxt = cfg.twait_ticks; rk = tcf_pkg::RK_ACK;
              end else if (!rep_syn && !acceptable) begin
                if (!rst_f) rk = tcf_pkg::RK_ACK;
              end else if (rst_f) begin
                if (item.seg_seq != rnxt_r) begin
                  rk = tcf_pkg::RK_ACK;
                end else begin
                  pend_nxt = 1'b0;
                  if ((st_r == tcf_pkg::ST_SYN_RCVD) && passive_r) begin
                    st_nxt = tcf_pkg::ST_LISTEN; pport_nxt = 16'd0;
                  end else begin
                    st_nxt = tcf_pkg::ST_CLOSED; ev = tcf_pkg::EV_RESET;
                  end
                end
              end else if (syn_f && !rep_syn) begin
                rk = tcf_pkg::RK_ACK;
              end else if (ack_f) begin
                cont = 1'b1;
                // Acknowledgment processing.
                if (st_r == tcf_pkg::ST_SYN_RCVD) begin
                  if (!(tcf_pkg::sq_before(suna_r, item.seg_ack) &&
                        tcf_pkg::sq_le(item.seg_ack, snxt_r))) begin
                    rk = tcf_pkg::RK_RST; cont = 1'b0;
                  end else begin
                    suna_nxt = item.seg_ack;
                    swnd_nxt = item.peer_window; wus_nxt = item.seg_seq;
                    wua_nxt = item.seg_ack;
                    pend_nxt = 1'b0; st_nxt = tcf_pkg::ST_ESTAB; became = 1'b1;
                  end
                end else begin
                  if (tcf_pkg::sq_before(snxt_r, item.seg_ack)) begin
                    rk = tcf_pkg::RK_ACK; cont = 1'b0;
                  end else begin
                    if (tcf_pkg::sq_before(suna_r, item.seg_ack)) begin
                      suna_nxt = item.seg_ack;
                      if (item.seg_ack == snxt_r) pend_nxt = 1'b0;
                    end
                    if (tcf_pkg::sq_before(wus_r, item.seg_seq) ||
                        ((wus_r == item.seg_seq) && tcf_pkg::sq_le(wua_r, item.seg_ack))) begin
                      swnd_nxt = item.peer_window; wus_nxt = item.seg_seq;
                      wua_nxt = item.seg_ack;
                    end
                  end
                end
                fin_acked = finsent_r && (suna_nxt == snxt_r);
                if (cont) begin
                  if ((st_nxt == tcf_pkg::ST_FIN_WAIT_1) && fin_acked) begin
                    st_nxt = tcf_pkg::ST_FIN_WAIT_2;
                  end else if ((st_nxt == tcf_pkg::ST_CLOSING) && fin_acked) begin
                    st_nxt = tcf_pkg::ST_TIME_WAIT; pend_nxt = 1'b0;
                    twc_nxt = cfg.twait_ticks; cont = 1'b0;
                  end else if ((st_nxt == tcf_pkg::ST_LAST_ACK) && fin_acked) begin
                    st_nxt = tcf_pkg::ST_CLOSED; ev = tcf_pkg::EV_CLOSED; cont = 1'b0;
                  end
                end
                if (cont) begin
                  if (item.data_len != 31'd0) begin
                    ev = tcf_pkg::EV_DATA;
                  end else if (!fin_f) begin
                    ev = became ? tcf_pkg::EV_ESTABLISHED : tcf_pkg::EV_NONE;
                  end else if (item.seg_seq != rnxt_r) begin
                    rk = tcf_pkg::RK_ACK;
                  end else begin
                    pfin = 1'b1;
                  end
                end
              end
            end
          end
        end
        tcf_pkg::ACT_PASSIVE: begin
          if ((st_r == tcf_pkg::ST_CLOSED) && (cfg.local_port != 16'd0)) begin
            pport_nxt = 16'd0; st_nxt = tcf_pkg::ST_LISTEN;
            passive_nxt = 1'b1; finsent_nxt = 1'b0;
          end
        end
        tcf_pkg::ACT_ACTIVE: begin
          if (((st_r == tcf_pkg::ST_CLOSED) || (st_r == tcf_pkg::ST_LISTEN)) &&
              (cfg.local_port != 16'd0) && (pport_r != 16'd0)) begin
            iss_nxt = item.init_seq; suna_nxt = item.init_seq;
            snxt_nxt = item.init_seq + 32'd1;
            passive_nxt = 1'b0; finsent_nxt = 1'b0;
            st_nxt = tcf_pkg::ST_SYN_SENT; rk = tcf_pkg::RK_SYN;
          end
        end
        tcf_pkg::ACT_CLOSE: begin
          if ((st_r == tcf_pkg::ST_LISTEN) || (st_r == tcf_pkg::ST_SYN_SENT)) begin
            st_nxt = tcf_pkg::ST_CLOSED; pend_nxt = 1'b0; ev = tcf_pkg::EV_CLOSED;
          end else if ((st_r == tcf_pkg::ST_ESTAB) || (st_r == tcf_pkg::ST_CLOSE_WAIT)) begin
            rk = tcf_pkg::RK_FIN_ACK;
            snxt_nxt = snxt_r + 32'd1; finsent_nxt = 1'b1;
            st_nxt = (st_r == tcf_pkg::ST_ESTAB) ? tcf_pkg::ST_FIN_WAIT_1
                                                 : tcf_pkg::ST_LAST_ACK;
          end
        end
        tcf_pkg::ACT_TICK: begin
          cont = 1'b1;
          if (st_r == tcf_pkg::ST_TIME_WAIT) begin
            if (twc_r <= 24'd1) begin
              twc_nxt = 24'd0; st_nxt = tcf_pkg::ST_CLOSED;
              ev = tcf_pkg::EV_CLOSED; cont = 1'b0;
            end else begin
              twc_nxt = twc_r - 24'd1;
            end
          end
          if (cont && pend_r) begin
            if (rtoc_r > 16'd1) begin
              rtoc_nxt = rtoc_r - 16'd1;
            end else begin
              rtoc_nxt = cfg.retx_ticks; rk = tcf_pkg::RK_RETX;
            end
          end
        end
        tcf_pkg::ACT_COMMIT_SENT: begin
          if (((st_r == tcf_pkg::ST_ESTAB) || (st_r == tcf_pkg::ST_CLOSE_WAIT)) &&
              !finsent_r && (item.seg_seq == snxt_r) &&
              (item.data_len <= tcf_pkg::MAX_SEND_COMMIT)) begin
            snxt_nxt = snxt_r + {1'b0, item.data_len}; acc = 1'b1;
          end
        end
        tcf_pkg::ACT_COMMIT_RCVD: begin
          if (synch && (st_r != tcf_pkg::ST_TIME_WAIT) &&
              !tcf_pkg::sq_before(item.seg_seq, rnxt_r) && (w0 <= {2'b00, rwnd_r})) begin
            rnxt_nxt = item.seg_seq; rwnd_nxt = item.peer_window; acc = 1'b1;
            if (item.fin_present && (item.fin_seq == item.seg_seq)) begin
              pfin = 1'b1;
            end else begin
              rk = tcf_pkg::RK_ACK;
            end
          end
        end
        default: begin
          if (synch) begin
            rwnd_nxt = item.peer_window; acc = 1'b1;
          end
        end
      endcase

      // Peer FIN taken in order.
      if (pfin) begin
        rnxt_nxt = rnxt_nxt + 32'd1;
        rk = tcf_pkg::RK_ACK; ev = tcf_pkg::EV_PEER_CLOSED;
        if ((st_nxt == tcf_pkg::ST_ESTAB) || (st_nxt == tcf_pkg::ST_SYN_RCVD)) begin
          st_nxt = tcf_pkg::ST_CLOSE_WAIT;
        end else if (st_nxt == tcf_pkg::ST_FIN_WAIT_1) begin
          if (finsent_nxt && (suna_nxt == snxt_nxt)) begin
            st_nxt = tcf_pkg::ST_TIME_WAIT; pend_nxt = 1'b0; twc_nxt = cfg.twait_ticks;
          end else begin
            st_nxt = tcf_pkg::ST_CLOSING;
          end
        end else if ((st_nxt == tcf_pkg::ST_FIN_WAIT_2) ||
                     (st_nxt == tcf_pkg::ST_TIME_WAIT)) begin
          st_nxt = tcf_pkg::ST_TIME_WAIT; pend_nxt = 1'b0; twc_nxt = cfg.twait_ticks;
        end
      end

      // A new control segment is kept for retransmission.
      if ((rk == tcf_pkg::RK_SYN) || (rk == tcf_pkg::RK_SYN_ACK) ||
          (rk == tcf_pkg::RK_FIN_ACK)) begin
        pend_nxt = 1'b1; rtoc_nxt = cfg.retx_ticks;
      end
    end else if (wr.wr && (st_r == tcf_pkg::ST_CLOSED)) begin
      // Register writes while closed also reload the live copies.
      if (wr.index == tcf_pkg::CFG_REMOTE_PORT) pport_nxt = wr.data[15:0];
      if (wr.index == tcf_pkg::CFG_RCV_WINDOW) rwnd_nxt = wr.data[29:0];
    end
  end

  // Reply segment fields from the reply kind.
  always_comb begin
    reply = '0;
    reply.event_res = ev;
    reply.accepted  = acc;
    reply.emit = (rk != tcf_pkg::RK_NONE);
    reply.out_src_port = cfg.local_port;
    case (rk)
      tcf_pkg::RK_NONE: reply.out_src_port = 16'd0;
      tcf_pkg::RK_ACK: begin
        reply.out_dst_port = pport_nxt; reply.out_seq = snxt_nxt;
        reply.out_ack = rnxt_nxt; reply.out_flags = tcf_pkg::FL_ACK;
        reply.out_window = wire_win;
      end
      tcf_pkg::RK_RST: begin
        reply.out_dst_port = item.seg_src_port;
        if (ack_f) begin
          reply.out_seq = item.seg_ack; reply.out_flags = tcf_pkg::FL_RST;
        end else begin
          reply.out_ack = item.seg_seq + seg_len; reply.out_flags = tcf_pkg::FL_RST_ACK;
        end
      end
      tcf_pkg::RK_SYN: begin
        reply.out_dst_port = pport_nxt; reply.out_seq = item.init_seq;
        reply.out_flags = tcf_pkg::FL_SYN; reply.out_window = wire_win;
      end
      tcf_pkg::RK_SYN_ACK: begin
        reply.out_dst_port = pport_nxt; reply.out_seq = iss_nxt;
        reply.out_ack = rnxt_nxt; reply.out_flags = tcf_pkg::FL_SYN_ACK;
        reply.out_window = wire_win;
      end
      tcf_pkg::RK_FIN_ACK: begin
        reply.out_dst_port = pport_nxt; reply.out_seq = snxt_r;
        reply.out_ack = rnxt_nxt; reply.out_flags = tcf_pkg::FL_FIN_ACK;
        reply.out_window = wire_win;
      end
      tcf_pkg::RK_RETX: begin
        reply.out_src_port = sv_sp_r; reply.out_dst_port = sv_dp_r;
        reply.out_seq = sv_seq_r; reply.out_ack = sv_ack_r;
        reply.out_flags = sv_flags_r; reply.out_window = sv_win_r;
      end
      default: reply.emit = 1'b0;
    endcase
  end

  // Connection state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tcf_pkg::ST_CLOSED;
      suna_r <= '0; snxt_r <= '0; swnd_r <= '0; wus_r <= '0; wua_r <= '0;
      rnxt_r <= '0; rwnd_r <= tcf_pkg::RST_RCV_WINDOW; iss_r <= '0; irs_r <= '0;
      pport_r <= tcf_pkg::RST_REMOTE_PORT;
      passive_r <= 1'b0; finsent_r <= 1'b0; pend_r <= 1'b0;
      rtoc_r <= '0; twc_r <= '0;
      sv_seq_r <= '0; sv_ack_r <= '0; sv_sp_r <= '0; sv_dp_r <= '0;
      sv_flags_r <= '0; sv_win_r <= '0;
    end else begin
      st_r <= st_nxt;
      suna_r <= suna_nxt; snxt_r <= snxt_nxt; swnd_r <= swnd_nxt;
      wus_r <= wus_nxt; wua_r <= wua_nxt; rnxt_r <= rnxt_nxt; rwnd_r <= rwnd_nxt;
      iss_r <= iss_nxt; irs_r <= irs_nxt; pport_r <= pport_nxt;
      passive_r <= passive_nxt; finsent_r <= finsent_nxt; pend_r <= pend_nxt;
      rtoc_r <= rtoc_nxt; twc_r <= twc_nxt;
      if (go && ((rk == tcf_pkg::RK_SYN) || (rk == tcf_pkg::RK_SYN_ACK) ||
                 (rk == tcf_pkg::RK_FIN_ACK))) begin
        sv_seq_r <= reply.out_seq; sv_ack_r <= reply.out_ack;
        sv_sp_r <= reply.out_src_port; sv_dp_r <= reply.out_dst_port;
        sv_flags_r <= reply.out_flags; sv_win_r <= reply.out_window;
      end
    end
  end

endmodule

// File: hdl/tcp_connection_control_fsm_core.sv
// Top level of the TCP connection control engine.
//   channel | direction | contents
//   in_ch   | sink      | one event request per handshake
//   out_ch  | source    | one result per request, in order
//   cfg_ch  | sink      | register index and write data, always ready
// One request per cycle is sustained while out_ch is ready; results are registered.
// The limit is the per-request update of the connection state registers.
// Reset is synchronous and active low and restores all register reset values.
// A stalled result holds in the result register while one more request waits
// in the input register; further requests are held off by in_ch.ready.
module tcp_connection_control_fsm_core (
  input logic        clk,
  input logic        rst_n,
  tcf_in_if.sink     in_ch,
  tcf_out_if.source  out_ch,
  tcf_cfg_if.sink    cfg_ch
);

  logic             s_valid_r, o_valid_r, advance;
  tcf_pkg::item_t   s_item_r;
  tcf_pkg::reply_t  o_reply_r, reply;
  tcf_pkg::cfg_t    cfg;
  tcf_pkg::cfg_wr_t wr;

  assign advance     = s_valid_r && (!o_valid_r || out_ch.ready);
  assign in_ch.ready = !s_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign wr.wr    = cfg_ch.valid;
  assign wr.index = cfg_ch.index;
  assign wr.data  = cfg_ch.data;

  tcf_cfg_regs u_cfg (.clk(clk), .rst_n(rst_n), .wr(wr), .cfg(cfg));

  tcf_engine u_eng (
    .clk(clk), .rst_n(rst_n), .go(advance), .item(s_item_r),
    .cfg(cfg), .wr(wr), .reply(reply)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s_item_r.action       <= in_ch.action;
      s_item_r.seg_src_port <= in_ch.seg_src_port;
      s_item_r.seg_dst_port <= in_ch.seg_dst_port;
      s_item_r.seg_seq      <= in_ch.seg_seq;
      s_item_r.seg_ack      <= in_ch.seg_ack;
      s_item_r.seg_flags    <= in_ch.seg_flags;
      s_item_r.data_len     <= in_ch.data_len;
      s_item_r.peer_window  <= in_ch.peer_window;
      s_item_r.init_seq     <= in_ch.init_seq;
      s_item_r.fin_present  <= in_ch.fin_present;
      s_item_r.fin_seq      <= in_ch.fin_seq;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (advance) begin
      o_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) o_reply_r <= reply;
  end

  assign out_ch.valid        = o_valid_r;
  assign out_ch.emit         = o_reply_r.emit;
  assign out_ch.out_src_port = o_reply_r.out_src_port;
  assign out_ch.out_dst_port = o_reply_r.out_dst_port;
  assign out_ch.out_seq      = o_reply_r.out_seq;
  assign out_ch.out_ack      = o_reply_r.out_ack;
  assign out_ch.out_flags    = o_reply_r.out_flags;
  assign out_ch.out_window   = o_reply_r.out_window;
  assign out_ch.event_res    = o_reply_r.event_res;
  assign out_ch.accepted     = o_reply_r.accepted;

endmodule

// File: hdl/tcf_checker.sv
// Port-level assertions for the TCP control engine and their binding.
module tcf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        emit,
  input logic [31:0] out_seq,
  input logic [31:0] out_ack,
  input logic [7:0]  out_flags,
  input logic [15:0] out_window,
  input logic [2:0]  event_res
);

  // A stalled result keeps its sequence number and flags.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_seq) && $stable(out_flags))
    else $error("result changed while stalled");

  // No result is offered right after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Event codes stay in their defined range.
  a_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> event_res <= 3'd5)
    else $error("undefined event code");

  // Without a segment the sequence, acknowledgment, flag and window fields are zero.
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !emit |-> out_seq == 32'd0 && out_ack == 32'd0 && out_flags == 8'd0 &&
    out_window == 16'd0)
    else $error("segment fields set without emit");

  // A reset segment advertises no window.
  a_rst_win: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && emit && out_flags[2] |-> out_window == 16'd0)
    else $error("reset segment carries a window");

endmodule

bind tcp_connection_control_fsm_core tcf_checker u_tcf_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .emit(out_ch.emit), .out_seq(out_ch.out_seq), .out_ack(out_ch.out_ack),
  .out_flags(out_ch.out_flags), .out_window(out_ch.out_window),
  .event_res(out_ch.event_res)
);
